// ===== rtl/core/pasf_pkg.sv =====
package pasf_pkg;

   localparam int MAX_ROW_PIXELS = 1024;
   localparam int ROW_BYTES      = 3 * MAX_ROW_PIXELS;
   localparam int STORE_DEPTH    = 2 * ROW_BYTES;
   localparam int POS_W          = $clog2(ROW_BYTES + 1);
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int PIX_W          = 11;
   localparam int SCORE_W        = 19;
   localparam int NUM_FILTERS    = 5;
   localparam int FILT_IDX_W     = 3;
   localparam int KIND_W         = 2;
   localparam int LEFT_DIST      = 3;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

   localparam logic [FILT_IDX_W-1:0] FILT_NONE    = 3'd0;
   localparam logic [FILT_IDX_W-1:0] FILT_SUB     = 3'd1;
   localparam logic [FILT_IDX_W-1:0] FILT_UP      = 3'd2;
   localparam logic [FILT_IDX_W-1:0] FILT_AVERAGE = 3'd3;
   localparam logic [FILT_IDX_W-1:0] FILT_PAETH   = 3'd4;

   typedef logic [7:0] data_type;
   typedef logic [NUM_FILTERS-1:0][7:0] filt_vec_type;

   typedef struct packed {
      logic clear;
      logic accum;
      logic pick;
   } score_ctl_type;

   typedef struct packed {
      logic                  done;
      logic [FILT_IDX_W-1:0] best;
   } score_sts_type;

   // Magnitude of a filtered byte read as a signed value.
   function automatic data_type cost_of(input data_type v);
      data_type neg;
      begin
         neg = ~v + 8'd1;
         cost_of = v[7] ? neg : v;
      end
   endfunction

endpackage

// ===== rtl/core/pasf_ram.sv =====
module pasf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 6144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pasf_filter.sv =====
module pasf_filter
   import pasf_pkg::*;
(
   input  logic         clock,
   input  logic         load,
   input  data_type     cur,
   input  data_type     left,
   input  data_type     up,
   input  data_type     up_left,
   output filt_vec_type filt
);

   filt_vec_type filt_ff;
   filt_vec_type filt_in;

   logic [8:0] sum_ab;
   logic [9:0] c_twice;
   logic [9:0] pa;
   logic [9:0] pb;
   logic [9:0] pc;
   data_type   avg;
   data_type   paeth;

   always_comb begin
      sum_ab  = {1'b0, left} + {1'b0, up};
      c_twice = {1'b0, up_left, 1'b0};
      avg     = sum_ab[8:1];
      pa      = (up >= up_left) ? 10'(up - up_left) : 10'(up_left - up);
      pb      = (left >= up_left) ? 10'(left - up_left) : 10'(up_left - left);
      pc      = ({1'b0, sum_ab} >= c_twice) ? ({1'b0, sum_ab} - c_twice)
                                            : (c_twice - {1'b0, sum_ab});
      if (pa <= pb && pa <= pc) begin
         paeth = left;
      end else if (pb <= pc) begin
         paeth = up;
      end else begin
         paeth = up_left;
      end
      filt_in               = '0;
      filt_in[FILT_NONE]    = cur;
      filt_in[FILT_SUB]     = cur - left;
      filt_in[FILT_UP]      = cur - up;
      filt_in[FILT_AVERAGE] = cur - avg;
      filt_in[FILT_PAETH]   = cur - paeth;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         filt_ff <= filt_in;
      end
   end

   assign filt = filt_ff;

endmodule

// ===== rtl/core/pasf_score.sv =====
module pasf_score
   import pasf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  score_ctl_type ctl,
   input  filt_vec_type  filt,
   output score_sts_type sts
);

   logic [SCORE_W-1:0]    scores_ff [NUM_FILTERS];
   logic [SCORE_W-1:0]    scores_in [NUM_FILTERS];
   logic                  picking_ff;
   logic                  picking_in;
   logic [FILT_IDX_W-1:0] idx_ff;
   logic [FILT_IDX_W-1:0] idx_in;
   logic [FILT_IDX_W-1:0] best_idx_ff;
   logic [FILT_IDX_W-1:0] best_idx_in;
   logic [SCORE_W-1:0]    best_val_ff;
   logic [SCORE_W-1:0]    best_val_in;
   logic [SCORE_W-1:0]    cand;
   logic                  less;
   logic [SCORE_W:0]      sum;

   localparam logic [FILT_IDX_W-1:0] LAST_IDX = FILT_IDX_W'(NUM_FILTERS - 1);

   always_comb begin
      cand = scores_ff[idx_ff];
      less = cand < best_val_ff;
      for (int t = 0; t < NUM_FILTERS; t++) begin
         sum = {1'b0, scores_ff[t]} + (SCORE_W + 1)'(cost_of(filt[t]));
         if (ctl.clear) begin
            scores_in[t] = '0;
         end else if (ctl.accum) begin
            scores_in[t] = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
         end else begin
            scores_in[t] = scores_ff[t];
         end
      end

      picking_in  = picking_ff;
      idx_in      = idx_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      if (ctl.pick) begin
         // Type 0 seeds the search; a strict compare keeps ties on the lower type.
         picking_in  = 1'b1;
         idx_in      = FILT_IDX_W'(1);
         best_idx_in = FILT_NONE;
         best_val_in = scores_ff[FILT_NONE];
      end else if (picking_ff) begin
         if (less) begin
            best_idx_in = idx_ff;
            best_val_in = cand;
         end
         idx_in = idx_ff + FILT_IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            picking_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_FILTERS; t++) begin
            scores_ff[t] <= '0;
         end
         picking_ff <= 1'b0;
      end else begin
         for (int t = 0; t < NUM_FILTERS; t++) begin
            scores_ff[t] <= scores_in[t];
         end
         picking_ff <= picking_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
   end

   assign sts.done = picking_ff && (idx_ff == LAST_IDX);
   assign sts.best = less ? idx_ff : best_idx_ff;

endmodule

// ===== rtl/core/png_adaptive_scanline_filter_top.sv =====
// Accepted pushes return no result and keep the block busy through fetch, filter and score;
// on the last byte of a row the five filter scores are then compared one per cycle.
// A read of a data byte is busy for four row-store reads, the store's read latency, a filter
// step and an output step; its result strobes in the cycle after the output step.
// Refused pushes, empty reads and type-byte reads strobe in the cycle after acceptance.
// Synchronous reset clears control state; the row store is not cleared. The receiver cannot stall.
module png_adaptive_scanline_filter_top
   import pasf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_mode,
   input  logic [7:0]        req_pixel_byte,
   input  logic              req_image_start,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_byte,
   output logic [KIND_W-1:0] rsp_kind,
   output logic              rsp_row_last,
   input  logic              csr_write_en,
   input  logic [PIX_W-1:0]  csr_write_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FETCH   = 3'd1;
   localparam logic [2:0] ST_FILT    = 3'd2;
   localparam logic [2:0] ST_SCORE   = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;
   localparam logic [2:0] ST_PICK_GO = 3'd5;
   localparam logic [2:0] ST_PICK    = 3'd6;

   localparam logic [2:0] FETCH_LAST = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  bank_ff, bank_in;
   logic                  top_row_ff, top_row_in;
   logic [POS_W-1:0]      fill_ff, fill_in;
   logic                  pending_ff, pending_in;
   logic [FILT_IDX_W-1:0] chosen_ff, chosen_in;
   logic [POS_W-1:0]      rp_ff, rp_in;
   logic [PIX_W-1:0]      csr_ff, csr_in;
   logic [POS_W-1:0]      x_ff, x_in;
   data_type              byte_ff, byte_in;
   logic                  is_push_ff, is_push_in;
   data_type              opnd_ff [4];
   logic                  rsp_valid_ff, rsp_valid_in;
   data_type              rsp_byte_ff, rsp_byte_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [PIX_W-1:0]      pix_eff;
   logic [POS_W-1:0]      row_len;
   logic                  ge3;
   logic [POS_W-1:0]      x_back;
   logic [ADDR_W-1:0]     cur_base;
   logic [ADDR_W-1:0]     up_base;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ADDR_W-1:0]     ram_wr_addr;
   data_type              ram_rd_data;
   logic                  ram_we;
   logic [1:0]            slot;
   logic [POS_W-1:0]      fill_next;

   data_type              f_cur, f_left, f_up, f_up_left;
   logic                  filt_load;
   filt_vec_type          filt;
   score_ctl_type         ctl;
   score_sts_type         sts;

   // Effective row length in bytes, with the pixel count clamped to its legal range.
   always_comb begin
      if (csr_ff == '0) begin
         pix_eff = PIX_W'(1);
      end else if (csr_ff > PIX_W'(MAX_ROW_PIXELS)) begin
         pix_eff = PIX_W'(MAX_ROW_PIXELS);
      end else begin
         pix_eff = csr_ff;
      end
      row_len = POS_W'(3) * POS_W'(pix_eff);
   end

   always_comb begin
      ge3       = x_ff >= POS_W'(LEFT_DIST);
      x_back    = ge3 ? (x_ff - POS_W'(LEFT_DIST)) : x_ff;
      cur_base  = bank_ff ? ADDR_W'(ROW_BYTES) : '0;
      up_base   = bank_ff ? '0 : ADDR_W'(ROW_BYTES);
      ram_wr_addr = cur_base + ADDR_W'(x_ff);
      unique case (cnt_ff)
         3'd0:    ram_rd_addr = cur_base + ADDR_W'(x_ff);
         3'd1:    ram_rd_addr = cur_base + ADDR_W'(x_back);
         3'd2:    ram_rd_addr = up_base + ADDR_W'(x_ff);
         3'd3:    ram_rd_addr = up_base + ADDR_W'(x_back);
         default: ram_rd_addr = cur_base + ADDR_W'(x_ff);
      endcase
      slot      = 2'(cnt_ff - 3'd1);
      fill_next = x_ff + POS_W'(1);
   end

   // Neighbors outside the row, or above the first row of an image, read as zero.
   always_comb begin
      f_cur     = is_push_ff ? byte_ff : opnd_ff[0];
      f_left    = ge3 ? opnd_ff[1] : '0;
      f_up      = top_row_ff ? '0 : opnd_ff[2];
      f_up_left = (!top_row_ff && ge3) ? opnd_ff[3] : '0;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bank_in      = bank_ff;
      top_row_in   = top_row_ff;
      fill_in      = fill_ff;
      pending_in   = pending_ff;
      chosen_in    = chosen_ff;
      rp_in        = rp_ff;
      csr_in       = csr_write_en ? csr_write_data : csr_ff;
      x_in         = x_ff;
      byte_in      = byte_ff;
      is_push_in   = is_push_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = 1'b0;
      ram_we       = 1'b0;
      filt_load    = 1'b0;
      ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == MODE_PUSH) begin
                  if (pending_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = '0;
                     rsp_kind_in  = KIND_REFUSED;
                  end else begin
                     if (req_image_start) begin
                        top_row_in = 1'b1;
                        ctl.clear  = 1'b1;
                        x_in       = '0;
                     end else begin
                        x_in = fill_ff;
                     end
                     byte_in    = req_pixel_byte;
                     is_push_in = 1'b1;
                     cnt_in     = '0;
                     state_in   = ST_FETCH;
                  end
               end else begin
                  if (!pending_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = '0;
                     rsp_kind_in  = KIND_EMPTY;
                  end else if (rp_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = 8'(chosen_ff);
                     rsp_kind_in  = KIND_TYPE;
                     rp_in        = POS_W'(1);
                  end else begin
                     x_in       = rp_ff - POS_W'(1);
                     is_push_in = 1'b0;
                     cnt_in     = '0;
                     state_in   = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == FETCH_LAST) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            filt_load = 1'b1;
            state_in  = is_push_ff ? ST_SCORE : ST_EMIT;
         end
         ST_SCORE: begin
            ctl.accum = 1'b1;
            ram_we    = 1'b1;
            if (fill_next >= row_len) begin
               state_in = ST_PICK_GO;
            end else begin
               fill_in  = fill_next;
               state_in = ST_IDLE;
            end
         end
         ST_PICK_GO: begin
            ctl.pick = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (sts.done) begin
               chosen_in  = sts.best;
               pending_in = 1'b1;
               rp_in      = '0;
               fill_in    = '0;
               ctl.clear  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = filt[chosen_ff];
            rsp_kind_in  = KIND_DATA;
            if (rp_ff >= row_len) begin
               rsp_last_in = 1'b1;
               pending_in  = 1'b0;
               bank_in     = ~bank_ff;
               top_row_in  = 1'b0;
               rp_in       = '0;
            end else begin
               rp_in = rp_ff + POS_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         top_row_ff   <= 1'b1;
         fill_ff      <= '0;
         pending_ff   <= 1'b0;
         chosen_ff    <= FILT_NONE;
         rp_ff        <= '0;
         csr_ff       <= PIX_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bank_ff      <= bank_in;
         top_row_ff   <= top_row_in;
         fill_ff      <= fill_in;
         pending_ff   <= pending_in;
         chosen_ff    <= chosen_in;
         rp_ff        <= rp_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      byte_ff     <= byte_in;
      is_push_ff  <= is_push_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      // Read data arrives in the cycle after its address, so fetch step k fills operand k-1.
      if (state_ff == ST_FETCH && cnt_ff != '0) begin
         opnd_ff[slot] <= ram_rd_data;
      end
   end

   pasf_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (byte_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pasf_filter u_filter (
      .clock   (clock),
      .load    (filt_load),
      .cur     (f_cur),
      .left    (f_left),
      .up      (f_up),
      .up_left (f_up_left),
      .filt    (filt)
   );

   pasf_score u_score (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .filt  (filt),
      .sts   (sts)
   );

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_row_last = rsp_last_ff;

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted word");

   a_data_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DATA) |-> $past(state_ff == ST_EMIT))
      else $error("data word issued outside the output step");

   a_last_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_last) |-> (!pending_ff && rsp_kind == KIND_DATA))
      else $error("row end did not release the pending row");

endmodule

// ===== tb/tb_png_adaptive_scanline_filter_top.sv =====
`timescale 1ns / 1ps

module tb_png_adaptive_scanline_filter_top
   import pasf_pkg::*;
();

   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int RUN_LIMIT_NS   = 20_000_000;
   localparam int MAX_REPORTS    = 100;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic [KIND_W-1:0] kind;
      logic              row_last;
   } out_word_type;

   typedef struct packed {
      logic      mode;
      logic [7:0] pixel;
      logic      img;
      logic      typed;
      out_word_type word;
   } warmup_row_type;

   localparam out_word_type EMPTY_WORD   = '{8'h00, KIND_EMPTY, 1'b0};
   localparam out_word_type REFUSED_WORD = '{8'h00, KIND_REFUSED, 1'b0};

   // Row length is one pixel after reset, so three pushes make a row.
   localparam warmup_row_type WARMUP [0:23] = '{
      '{MODE_READ, 8'h00, 1'b0, 1'b1, EMPTY_WORD},
      '{MODE_PUSH, 8'h00, 1'b1, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'hFF, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h80, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h7F, 1'b1, 1'b1, REFUSED_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h01, 1'b0, 1'b1, REFUSED_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b1, EMPTY_WORD},
      '{MODE_PUSH, 8'h7F, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h81, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_READ, 8'h00, 1'b1, 1'b1, EMPTY_WORD},
      '{MODE_PUSH, 8'h55, 1'b1, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'hAA, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h55, 1'b1, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'h2A, 1'b0, 1'b0, EMPTY_WORD},
      '{MODE_PUSH, 8'hD5, 1'b0, 1'b0, EMPTY_WORD}
   };

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_mode;
   logic [7:0]        req_pixel_byte;
   logic              req_image_start;
   logic              rsp_valid;
   logic [7:0]        rsp_out_byte;
   logic [KIND_W-1:0] rsp_kind;
   logic              rsp_row_last;
   logic              csr_write_en;
   logic [PIX_W-1:0]  csr_write_data;

   // Own copy of the filter state.
   bit [7:0]              px_store [STORE_DEPTH];
   bit                    cur_bank = 1'b0;
   bit                    first_row = 1'b1;
   int                    fill_pos = 0;
   int unsigned           score [NUM_FILTERS];
   bit                    row_pending = 1'b0;
   bit [FILT_IDX_W-1:0]   chosen_filter = '0;
   int                    rd_pos = 0;
   bit [PIX_W-1:0]        row_pix_reg = 1;

   out_word_type out_stream_q [$];
   out_word_type head_word;
   int        mismatch_count = 0;
   int        idle_pct = 33;
   int        random_items = 0;

   png_adaptive_scanline_filter_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_pixel_byte  (req_pixel_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_row_last    (rsp_row_last),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("** png_adaptive_scanline_filter_top: FAILED **");
      $finish;
   end

   function automatic int row_len_bytes();
      int p;
      p = row_pix_reg;
      if (p == 0) p = 1;
      if (p > MAX_ROW_PIXELS) p = MAX_ROW_PIXELS;
      return 3 * p;
   endfunction

   function automatic logic [7:0] filtered_byte(input logic [FILT_IDX_W-1:0] ftype,
                                                input int x);
      int cur_base, up_base, cur, a, b, c, pred, pa, pb, pc;
      cur_base = cur_bank * ROW_BYTES;
      up_base  = (cur_bank ^ 1'b1) * ROW_BYTES;
      if (x >= ROW_BYTES) x = ROW_BYTES - 1;
      cur = px_store[cur_base + x];
      a = (x >= LEFT_DIST) ? px_store[cur_base + x - LEFT_DIST] : 0;
      b = first_row ? 0 : px_store[up_base + x];
      c = (!first_row && x >= LEFT_DIST) ? px_store[up_base + x - LEFT_DIST] : 0;
      case (ftype)
         FILT_SUB:     pred = a;
         FILT_UP:      pred = b;
         FILT_AVERAGE: pred = (a + b) / 2;
         FILT_PAETH: begin
            pa = (b >= c) ? b - c : c - b;
            pb = (a >= c) ? a - c : c - a;
            pc = a + b - 2 * c;
            if (pc < 0) pc = -pc;
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc) pred = b;
            else pred = c;
         end
         default: pred = 0;
      endcase
      return 8'(cur - pred);
   endfunction

   // Advances the filter state by one accepted word and gives the word it returns, if any.
   task automatic row_filter_step(input logic mode, input logic [7:0] pixel, input logic img,
                                  output bit has_word, output out_word_type word);
      int len, pos, best;
      int unsigned s;
      logic [7:0] v;
      len = row_len_bytes();
      has_word = 1'b1;
      word = EMPTY_WORD;
      if (mode == MODE_PUSH) begin
         if (row_pending) begin
            word.kind = KIND_REFUSED;
         end else begin
            has_word = 1'b0;
            if (img) begin
               first_row = 1'b1;
               fill_pos = 0;
               for (int t = 0; t < NUM_FILTERS; t++) score[t] = 0;
            end
            pos = (fill_pos >= ROW_BYTES) ? ROW_BYTES - 1 : fill_pos;
            px_store[cur_bank * ROW_BYTES + pos] = pixel;
            for (int t = 0; t < NUM_FILTERS; t++) begin
               v = filtered_byte(FILT_IDX_W'(t), pos);
               s = score[t] + (v[7] ? 256 - v : v);
               score[t] = (s > SCORE_MAX) ? SCORE_MAX : s;
            end
            fill_pos = pos + 1;
            if (fill_pos >= len) begin
               best = 0;
               for (int t = 1; t < NUM_FILTERS; t++)
                  if (score[t] < score[best]) best = t;
               chosen_filter = FILT_IDX_W'(best);
               row_pending = 1'b1;
               rd_pos = 0;
               fill_pos = 0;
               for (int t = 0; t < NUM_FILTERS; t++) score[t] = 0;
            end
         end
      end else if (row_pending) begin
         if (rd_pos == 0) begin
            word.out_byte = 8'(chosen_filter);
            word.kind = KIND_TYPE;
            rd_pos = 1;
         end else begin
            word.kind = KIND_DATA;
            word.row_last = (rd_pos >= len);
            word.out_byte = filtered_byte(chosen_filter, rd_pos - 1);
            if (word.row_last) begin
               row_pending = 1'b0;
               cur_bank ^= 1'b1;
               first_row = 1'b0;
               rd_pos = 0;
            end else begin
               rd_pos++;
            end
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(input logic mode, input logic [7:0] pixel, input logic img,
                            input logic typed, input out_word_type typed_word);
      bit has_word;
      out_word_type word;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_pixel_byte <= pixel;
      req_image_start <= img;
      @(posedge clock);
      while (busy) @(posedge clock);
      row_filter_step(mode, pixel, img, has_word, word);
      if (typed) begin
         has_word = 1'b1;
         word = typed_word;
      end
      if (has_word) out_stream_q = {out_stream_q, word};
   endtask

   task automatic push_px(input logic [7:0] pixel, input logic img);
      send_word(MODE_PUSH, pixel, img, 1'b0, EMPTY_WORD);
   endtask

   task automatic pull_out();
      send_word(MODE_READ, 8'($urandom), 1'($urandom), 1'b0, EMPTY_WORD);
   endtask

   // A push may still be in flight after the last result, so wait out its latency too.
   task automatic settle();
      start <= 1'b0;
      while (out_stream_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_pixels(input int unsigned value);
      csr_write_data <= PIX_W'(value);
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      row_pix_reg = PIX_W'(value);
   endtask

   // Pushes until a row is complete. Row content follows one of several shapes so that
   // every filter type gets to win now and then.
   task automatic fill_row(input bit new_image, input bit noisy);
      int shape, level, p, lft, up, upl, v;
      bit img, has_left, has_up;
      shape = $urandom_range(0, 5);
      level = $urandom_range(0, 255);
      img = new_image;
      while (!row_pending) begin
         if (noisy && $urandom_range(99) < 6) pull_out();
         if (noisy && $urandom_range(999) < 3) img = 1'b1;
         p = img ? 0 : fill_pos;
         has_left = (p >= LEFT_DIST);
         has_up = !img && !first_row;
         lft = has_left ? px_store[cur_bank * ROW_BYTES + p - LEFT_DIST] : level;
         up = has_up ? px_store[(cur_bank ^ 1'b1) * ROW_BYTES + p] : level;
         upl = (has_left && has_up) ?
               px_store[(cur_bank ^ 1'b1) * ROW_BYTES + p - LEFT_DIST] : up;
         v = $urandom_range(0, 6) - 3;
         case (shape)
            0: v = $urandom_range(0, 255);
            1: v += lft;
            2: v += up;
            3: v += (lft + up) / 2;
            4: v += lft + up - upl;
            default: v = level;
         endcase
         push_px(8'(v), img);
         img = 1'b0;
         random_items++;
      end
   endtask

   task automatic drain_row(input bit noisy);
      while (row_pending) begin
         if (noisy && $urandom_range(99) < 8) push_px(8'($urandom), 1'($urandom));
         pull_out();
         random_items++;
      end
      if (noisy && $urandom_range(9) == 0) pull_out();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (out_stream_q.size() == 0) begin
            flag_mismatch("unexpected word", rsp_kind, 0);
         end else begin
            head_word = out_stream_q.pop_front();
            if (rsp_out_byte !== head_word.out_byte)
               flag_mismatch("out_byte", rsp_out_byte, head_word.out_byte);
            if (rsp_kind !== head_word.kind)
               flag_mismatch("kind", rsp_kind, head_word.kind);
            if (rsp_row_last !== head_word.row_last)
               flag_mismatch("row_last", rsp_row_last, head_word.row_last);
         end
      end
   end

   initial begin
      int sel, pix, rows, len, part;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_PUSH;
      req_pixel_byte <= 8'h00;
      req_image_start <= 1'b0;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      for (int t = 0; t < NUM_FILTERS; t++) score[t] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(WARMUP); i++)
         send_word(WARMUP[i].mode, WARMUP[i].pixel, WARMUP[i].img, WARMUP[i].typed,
                   WARMUP[i].word);
      drain_row(1'b0);

      // Shrink the row while it is being filled: the next push ends it.
      settle();
      write_row_pixels(4);
      for (int i = 0; i < 7; i++) push_px(8'($urandom), i == 0);
      settle();
      write_row_pixels(2);
      push_px(8'($urandom), 1'b0);
      drain_row(1'b0);

      // Shrink the row during read-out: the next data word is the last one.
      settle();
      write_row_pixels(3);
      fill_row(1'b1, 1'b0);
      repeat (4) pull_out();
      settle();
      write_row_pixels(1);
      drain_row(1'b0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 10) pix = 0;
         else if (sel < 75) pix = $urandom_range(1, 6);
         else pix = $urandom_range(7, 40);
         idle_pct = (random_items >= 600 && random_items < 900) ? 0 : 33;
         settle();
         write_row_pixels(pix);
         rows = $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            fill_row(r == 0, 1'b1);
            drain_row(1'b1);
         end
         // Now and then leave a new image unfinished; the next phase drops it.
         if ($urandom_range(9) == 0) begin
            len = row_len_bytes();
            part = $urandom_range(1, len - 1);
            for (int i = part; i > 0; i--)
               push_px(8'($urandom), i == part);
         end
      end

      idle_pct = 33;
      settle();
      if (mismatch_count == 0) begin
         $display("** png_adaptive_scanline_filter_top: PASSED **");
      end else begin
         $display("** png_adaptive_scanline_filter_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pasf_pkg.sv
rtl/core/pasf_ram.sv
rtl/core/pasf_filter.sv
rtl/core/pasf_score.sv
rtl/core/png_adaptive_scanline_filter_top.sv
tb/tb_png_adaptive_scanline_filter_top.sv
